// ----- hdl/mmu_pkg.sv -----
// Shared types and constants of the matrix multiply unit.
package mmu_pkg;

    // Control that travels with a result token along the cell chain
    typedef struct packed {
        logic valid;
        logic last;
        logic err;
    } t_ctl;

    localparam int VAL_W = 32;
    localparam int IDX_W = 2;
    // product, row, column, last, dim_error, saturated
    localparam int RES_W = VAL_W + 2 * IDX_W + 3;

    localparam logic [VAL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] SAT_NEG = 32'h8000_0000;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_COLS_A = 2'd1;
    localparam logic [1:0] REG_ROWS_B = 2'd2;
    localparam logic [1:0] REG_COLS_B = 2'd3;

endpackage

// ----- hdl/matrix_multiply_unit.sv -----
// Top level of the matrix multiply unit: registers, loader, sequencer, cell chain.
//
// Usage: set rows_a, cols_a, rows_b, cols_b over the APB port while the block is
// idle (0 acts as 1, above MAX_DIM acts as MAX_DIM); any register write drops a
// load in progress. Then stream the elements of A and then of B, row-major, one
// signed Q16.16 item per cycle on i_valid / o_stall.
// After the last element of B the input stalls; the sequencer waits for the
// result queue to empty, then sends one token per result element down a chain
// of MAX_DIM cells, each with a multiply stage and an add stage. Results leave
// one per cycle while the receiver does not hold i_stall, rows_a*cols_b in
// all, the last marked. The input reopens once the last token leaves the chain.
// A mismatch of cols_a and rows_b yields an identity of rows_a by cols_b with
// dim_error set. Results wait in a queue of MAX_DIM*MAX_DIM items while the
// receiver holds i_stall; nothing is lost. Reset restores the dimensions to 4,
// empties the queue and starts a fresh load; no clearing pass is needed.
module matrix_multiply_unit #(
    parameter int MAX_DIM   = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_element,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_product,
    output logic [1:0]         o_out_row,
    output logic [1:0]         o_out_col,
    output logic               o_last,
    output logic               o_dim_error,
    output logic               o_saturated
);
    import mmu_pkg::*;

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int SW    = 64 + $clog2(MAX_DIM) + 1;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam logic [31:0] ONE_VAL = (FRAC_BITS > 30) ? SAT_POS : 32'(64'd1 << FRAC_BITS);
    localparam logic        ONE_SAT = (FRAC_BITS > 30);

    typedef enum logic [1:0] {
        S_LOAD,
        S_WAIT,
        S_ISSUE,
        S_DRAIN
    } t_state;

    function automatic logic [DW-1:0] clamp_dim(input logic [2:0] v);
        if (v == 3'd0) begin
            return DW'(1);
        end
        if (int'(v) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end
        return DW'(v);
    endfunction

    logic [2:0]    r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    t_state        r_state;
    logic          r_ld_b;
    logic [IW-1:0] r_ld_i, r_ld_j;
    logic [IW-1:0] r_is_r, r_is_c;

    logic [DW-1:0] w_ra, w_ca, w_rb, w_cb;
    logic          w_cfg_wr, w_in_acc, w_pop;
    logic          w_ld_row_end, w_ld_col_end;
    logic          w_is_row_end, w_is_col_end;
    logic          w_fifo_empty, w_fifo_full;

    t_ctl                 w_ctl [MAX_DIM+1];
    logic [IW-1:0]        w_row [MAX_DIM+1];
    logic [IW-1:0]        w_col [MAX_DIM+1];
    logic signed [SW-1:0] w_sum [MAX_DIM+1];

    logic signed [SW-1:0] w_shift;
    logic                 w_fit;
    logic [31:0]          w_val;
    logic                 w_sat;
    logic [IW+1:0]        w_row_x, w_col_x;
    logic [RES_W-1:0]     w_res, w_head;

    assign w_ra = clamp_dim(r_rows_a);
    assign w_ca = clamp_dim(r_cols_a);
    assign w_rb = clamp_dim(r_rows_b);
    assign w_cb = clamp_dim(r_cols_b);

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            REG_ROWS_A: prdata = {29'd0, r_rows_a};
            REG_COLS_A: prdata = {29'd0, r_cols_a};
            REG_ROWS_B: prdata = {29'd0, r_rows_b};
            REG_COLS_B: prdata = {29'd0, r_cols_b};
            default:    prdata = '0;
        endcase
    end

    assign o_stall  = (r_state != S_LOAD);
    assign w_in_acc = i_valid && !o_stall;

    // Loading walks rows and columns of A, then of B
    assign w_ld_col_end = (DW'(r_ld_j) + DW'(1)) == (r_ld_b ? w_cb : w_ca);
    assign w_ld_row_end = (DW'(r_ld_i) + DW'(1)) == (r_ld_b ? w_rb : w_ra);
    assign w_is_col_end = (DW'(r_is_c) + DW'(1)) == w_cb;
    assign w_is_row_end = (DW'(r_is_r) + DW'(1)) == w_ra;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= 3'd4;
            r_cols_a <= 3'd4;
            r_rows_b <= 3'd4;
            r_cols_b <= 3'd4;
            r_state  <= S_LOAD;
            r_ld_b   <= 1'b0;
            r_ld_i   <= '0;
            r_ld_j   <= '0;
            r_is_r   <= '0;
            r_is_c   <= '0;
        end else begin
            if (w_cfg_wr) begin
                case (paddr[3:2])
                    REG_ROWS_A: r_rows_a <= pwdata[2:0];
                    REG_COLS_A: r_cols_a <= pwdata[2:0];
                    REG_ROWS_B: r_rows_b <= pwdata[2:0];
                    REG_COLS_B: r_cols_b <= pwdata[2:0];
                    default:    r_rows_a <= r_rows_a;
                endcase
                // drop any partial load
                r_ld_b <= 1'b0;
                r_ld_i <= '0;
                r_ld_j <= '0;
            end else begin
                case (r_state)
                    S_LOAD: begin
                        if (w_in_acc) begin
                            if (w_ld_col_end) begin
                                r_ld_j <= '0;
                                if (w_ld_row_end) begin
                                    r_ld_i <= '0;
                                    r_ld_b <= !r_ld_b;
                                    if (r_ld_b) begin
                                        r_state <= S_WAIT;
                                    end
                                end else begin
                                    r_ld_i <= r_ld_i + IW'(1);
                                end
                            end else begin
                                r_ld_j <= r_ld_j + IW'(1);
                            end
                        end
                    end
                    S_WAIT: begin
                        if (w_fifo_empty) begin
                            r_is_r  <= '0;
                            r_is_c  <= '0;
                            r_state <= S_ISSUE;
                        end
                    end
                    S_ISSUE: begin
                        if (w_is_col_end) begin
                            r_is_c <= '0;
                            if (w_is_row_end) begin
                                r_state <= S_DRAIN;
                            end else begin
                                r_is_r <= r_is_r + IW'(1);
                            end
                        end else begin
                            r_is_c <= r_is_c + IW'(1);
                        end
                    end
                    S_DRAIN: begin
                        if (w_ctl[MAX_DIM].valid && w_ctl[MAX_DIM].last) begin
                            r_state <= S_LOAD;
                        end
                    end
                    default: r_state <= S_LOAD;
                endcase
            end
        end
    end

    // Token into the head of the chain
    assign w_ctl[0].valid = (r_state == S_ISSUE);
    assign w_ctl[0].last  = w_is_col_end && w_is_row_end;
    assign w_ctl[0].err   = (w_ca != w_rb);
    assign w_row[0]       = r_is_r;
    assign w_col[0]       = r_is_c;
    assign w_sum[0]       = '0;

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        logic w_wa, w_wb;
        assign w_wa = w_in_acc && !r_ld_b && (r_ld_j == IW'(g));
        assign w_wb = w_in_acc && r_ld_b && (r_ld_i == IW'(g));

        mmu_cell #(
            .MAX_DIM (MAX_DIM),
            .IW      (IW),
            .SW      (SW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_a    (w_wa),
            .i_wr_b    (w_wb),
            .i_wr_addr (r_ld_b ? r_ld_j : r_ld_i),
            .i_wr_data (i_element),
            .i_active  (DW'(g) < w_ca),
            .i_ctl     (w_ctl[g]),
            .i_row     (w_row[g]),
            .i_col     (w_col[g]),
            .i_sum     (w_sum[g]),
            .o_ctl     (w_ctl[g+1]),
            .o_row     (w_row[g+1]),
            .o_col     (w_col[g+1]),
            .o_sum     (w_sum[g+1])
        );
    end

    // Floor-shift the full sum, then clip to 32 bits
    assign w_shift = w_sum[MAX_DIM] >>> FRAC_BITS;
    assign w_fit   = (w_shift == SW'(signed'(w_shift[31:0])));

    always_comb begin
        if (w_ctl[MAX_DIM].err) begin
            if (w_row[MAX_DIM] == w_col[MAX_DIM]) begin
                w_val = ONE_VAL;
                w_sat = ONE_SAT;
            end else begin
                w_val = '0;
                w_sat = 1'b0;
            end
        end else if (w_fit) begin
            w_val = w_shift[31:0];
            w_sat = 1'b0;
        end else begin
            w_val = w_shift[SW-1] ? SAT_NEG : SAT_POS;
            w_sat = 1'b1;
        end
    end

    assign w_row_x = (IW + 2)'(w_row[MAX_DIM]);
    assign w_col_x = (IW + 2)'(w_col[MAX_DIM]);
    assign w_res   = {w_val, w_row_x[1:0], w_col_x[1:0], w_ctl[MAX_DIM].last,
                      w_ctl[MAX_DIM].err, w_sat};

    assign w_pop = o_valid && !i_stall;

    mmu_out_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ctl[MAX_DIM].valid),
        .i_data  (w_res),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_empty (w_fifo_empty),
        .o_full  (w_fifo_full)
    );

    assign o_valid     = !w_fifo_empty;
    assign o_product   = signed'(w_head[RES_W-1 -: 32]);
    assign o_out_row   = w_head[6:5];
    assign o_out_col   = w_head[4:3];
    assign o_last      = w_head[2];
    assign o_dim_error = w_head[1];
    assign o_saturated = w_head[0];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[MAX_DIM].valid |-> !w_fifo_full)
        else $error("result queue overflow");

    a_last_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl[MAX_DIM].valid && w_ctl[MAX_DIM].last) |-> (r_state == S_DRAIN))
        else $error("last token left the chain outside drain");

    a_chain_quiet_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !w_ctl[MAX_DIM].valid)
        else $error("token in chain while loading");

    a_issue_from_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && !w_cfg_wr) ##1 (r_state == S_ISSUE) |-> $past(w_fifo_empty))
        else $error("issue started with queue not empty");

endmodule

// ----- hdl/mmu_cell.sv -----
// One multiply-accumulate cell: holds column k of A and row k of B.
module mmu_cell #(
    parameter int MAX_DIM = 4,
    parameter int IW      = 2,
    parameter int SW      = 67
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_a,
    input  logic                   i_wr_b,
    input  logic [IW-1:0]          i_wr_addr,
    input  logic signed [31:0]     i_wr_data,
    input  logic                   i_active,
    input  mmu_pkg::t_ctl          i_ctl,
    input  logic [IW-1:0]          i_row,
    input  logic [IW-1:0]          i_col,
    input  logic signed [SW-1:0]   i_sum,
    output mmu_pkg::t_ctl          o_ctl,
    output logic [IW-1:0]          o_row,
    output logic [IW-1:0]          o_col,
    output logic signed [SW-1:0]   o_sum
);
    import mmu_pkg::*;

    logic signed [31:0]   r_a [MAX_DIM];
    logic signed [31:0]   r_b [MAX_DIM];
    t_ctl                 r_ctl1;
    logic [IW-1:0]        r_row1;
    logic [IW-1:0]        r_col1;
    logic signed [SW-1:0] r_sum1;
    logic signed [63:0]   r_prod;
    t_ctl                 r_ctl2;
    logic [IW-1:0]        r_row2;
    logic [IW-1:0]        r_col2;
    logic signed [SW-1:0] r_sum2;

    always_ff @(posedge i_clk) begin
        if (i_wr_a) begin
            r_a[i_wr_addr] <= i_wr_data;
        end
        if (i_wr_b) begin
            r_b[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    // Multiply in the first stage, add in the second
    always_ff @(posedge i_clk) begin
        r_row1 <= i_row;
        r_col1 <= i_col;
        r_sum1 <= i_sum;
        if (i_active) begin
            r_prod <= r_a[i_row] * r_b[i_col];
        end else begin
            r_prod <= '0;
        end
        r_row2 <= r_row1;
        r_col2 <= r_col1;
        r_sum2 <= r_sum1 + SW'(r_prod);
    end

    assign o_ctl = r_ctl2;
    assign o_row = r_row2;
    assign o_col = r_col2;
    assign o_sum = r_sum2;

endmodule

// ----- hdl/mmu_out_fifo.sv -----
// Result queue in front of the output channel.
module mmu_out_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [mmu_pkg::RES_W-1:0]  i_data,
    input  logic                       i_pop,
    output logic [mmu_pkg::RES_W-1:0]  o_data,
    output logic                       o_empty,
    output logic                       o_full
);
    import mmu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [RES_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));

endmodule

// ----- dv/tb_matrix_multiply_unit.sv -----
// Self-checking testbench for the matrix multiply unit: predicted products against the output stream.
`timescale 1ns / 1ps

module tb_matrix_multiply_unit;
    import mmu_pkg::*;

    typedef struct {
        logic signed [31:0] product;
        logic [1:0] row;
        logic [1:0] col;
        logic last;
        logic err;
        logic sat;
    } t_res;

    class product_board;
        logic [2:0] dims [4];
        logic signed [31:0] mat_a [16];
        logic signed [31:0] mat_b [16];
        int unsigned n_loaded;
        t_res pending [$];
        int errors;

        function new();
            foreach (dims[i]) dims[i] = 3'd4;
            n_loaded = 0;
            errors = 0;
        endfunction

        function int unsigned eff(logic [2:0] v);
            if (v == 3'd0) return 1;
            if (v > 3'd4) return 4;
            return 32'(v);
        endfunction

        function void set_reg(int idx, logic [31:0] v);
            if (idx > 3) return;
            dims[idx] = v[2:0];
            n_loaded = 0;
        endfunction

        function void note_element(logic signed [31:0] e);
            int unsigned ra, ca, rb, cb, na, nb;
            logic signed [127:0] acc;
            logic signed [127:0] sh;
            t_res r;
            ra = eff(dims[REG_ROWS_A]); ca = eff(dims[REG_COLS_A]);
            rb = eff(dims[REG_ROWS_B]); cb = eff(dims[REG_COLS_B]);
            na = ra * ca; nb = rb * cb;
            if (n_loaded >= na + nb) n_loaded = 0;
            if (n_loaded < na) mat_a[n_loaded] = e;
            else mat_b[n_loaded - na] = e;
            n_loaded++;
            if (n_loaded < na + nb) return;
            n_loaded = 0;
            for (int i = 0; i < ra; i++) begin
                for (int j = 0; j < cb; j++) begin
                    r.row = i[1:0];
                    r.col = j[1:0];
                    r.last = (i == ra - 1) && (j == cb - 1);
                    r.err = (ca != rb);
                    r.sat = 1'b0;
                    if (r.err) begin
                        r.product = (i == j) ? 32'sh0001_0000 : 32'sh0;
                    end else begin
                        acc = 0;
                        for (int k = 0; k < ca; k++)
                            acc += 128'(mat_a[i*ca+k]) * 128'(mat_b[k*cb+j]);
                        sh = acc >>> 16;
                        if (sh > 128'sh7FFF_FFFF) begin
                            r.product = SAT_POS; r.sat = 1'b1;
                        end else if (sh < -128'sh8000_0000) begin
                            r.product = SAT_NEG; r.sat = 1'b1;
                        end else begin
                            r.product = sh[31:0];
                        end
                    end
                    pending.push_back(r);
                end
            end
        endfunction

        function void check_result(t_res got);
            t_res exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected item product=%h", $realtime, got.product);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.product !== exp_r.product) begin
                $display("%0t: product exp %h got %h", $realtime, exp_r.product, got.product);
                errors++;
            end
            if (got.row !== exp_r.row) begin
                $display("%0t: row exp %0d got %0d", $realtime, exp_r.row, got.row);
                errors++;
            end
            if (got.col !== exp_r.col) begin
                $display("%0t: col exp %0d got %0d", $realtime, exp_r.col, got.col);
                errors++;
            end
            if (got.last !== exp_r.last) begin
                $display("%0t: last exp %b got %b", $realtime, exp_r.last, got.last);
                errors++;
            end
            if (got.err !== exp_r.err) begin
                $display("%0t: dim_error exp %b got %b", $realtime, exp_r.err, got.err);
                errors++;
            end
            if (got.sat !== exp_r.sat) begin
                $display("%0t: saturated exp %b got %b", $realtime, exp_r.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [31:0] i_element = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [31:0] o_product;
    logic [1:0] o_out_row, o_out_col;
    logic o_last, o_dim_error, o_saturated;

    product_board board = new();
    int cycle_count = 0;
    int hold_len = 0;
    bit rx_random = 1'b1;

    matrix_multiply_unit u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: check on accept, then draw the stall for the next cycle
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.product = o_product; got.row = o_out_row; got.col = o_out_col;
            got.last = o_last; got.err = o_dim_error; got.sat = o_saturated;
            board.check_result(got);
        end
    end

    always @(negedge i_clk) begin
        if (hold_len > 0) begin
            i_stall <= 1'b1;
            hold_len <= hold_len - 1;
        end else if (rx_random) begin
            i_stall <= ($urandom_range(0, 7) < 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic write_reg(int idx, logic [31:0] v);
        i_valid <= 1'b0;
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 4'(idx * 4); pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        board.set_reg(idx, v);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Hold valid across items with no gap; drop it only while idling
    task automatic send_element(logic signed [31:0] e, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_element <= e;
        do @(posedge i_clk); while (o_stall);
        board.note_element(e);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (4 * 4 + 8) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic set_dims(int ra, int ca, int rb, int cb);
        drain();
        write_reg(REG_ROWS_A, ra);
        write_reg(REG_COLS_A, ca);
        write_reg(REG_ROWS_B, rb);
        write_reg(REG_COLS_B, cb);
    endtask

    initial begin
        int n, ra, ca, rb, cb;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: 1x1 extremes, saturation both ways, mismatch, zero and oversize dims
        set_dims(1, 1, 1, 1);
        send_element(32'sh7FFF_FFFF, 0); send_element(32'sh7FFF_FFFF, 0);
        send_element(32'sh8000_0000, 0); send_element(32'sh7FFF_FFFF, 0);
        send_element(32'sh0001_0000, 0); send_element(32'shFFFF_0000, 0);
        set_dims(0, 2, 3, 7);
        for (int i = 0; i < 2 + 12; i++) send_element(rand_elem(), 0);
        // Register write mid-load drops the partial load
        set_dims(2, 1, 1, 2);
        send_element(32'sh1234_5678, 0);
        write_reg(REG_COLS_B, 2);
        for (int i = 0; i < 4; i++) send_element(rand_elem(), 0);
        // Long receiver hold while the sender keeps offering: the first load fills the queue, the second waits
        set_dims(4, 4, 4, 4);
        rx_random = 1'b0;
        hold_len = 300;
        for (n = 0; n < 64; n++) send_element(rand_elem(), 0);
        drain();
        rx_random = 1'b1;
        n = 0;
        while (n < 180) begin
            ra = $urandom_range(0, 5); ca = $urandom_range(0, 5);
            rb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : ca;
            cb = $urandom_range(0, 7);
            set_dims(ra, ca, rb, cb);
            for (int s = 0; s < 2; s++) begin
                int tot;
                tot = board.eff(3'(ra)) * board.eff(3'(ca))
                    + board.eff(3'(rb)) * board.eff(3'(cb));
                for (int i = 0; i < tot; i++) send_element(rand_elem(), $urandom_range(0, 1));
                n += tot;
            end
        end
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/mmu_pkg.sv
hdl/mmu_cell.sv
hdl/mmu_out_fifo.sv
hdl/matrix_multiply_unit.sv
dv/tb_matrix_multiply_unit.sv
